/* hw/rtl/mvdi_pkg.sv */
// Shared types and codes of the mesh vertex deduplication indexer.
package mvdi_pkg;

   // Fixed field widths of the ports.
   localparam int VID_W      = 11;
   localparam int TEX_W      = 12;
   localparam int OIDX_W     = 12;
   localparam int OPART_W    = 10;
   localparam int SIZE_W     = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index carried on the upper address bit.
   localparam logic CSR_PARTICLE_COUNT = 1'b0;

   localparam logic [SIZE_W-1:0] SIZE_EDGE = 4'd2;
   localparam logic [SIZE_W-1:0] SIZE_TRI  = 4'd3;

   localparam logic [1:0] KIND_NEWV = 2'd0;
   localparam logic [1:0] KIND_EDGE = 2'd1;
   localparam logic [1:0] KIND_TRI  = 2'd2;
   localparam logic [1:0] KIND_REJ  = 2'd3;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_SIZE  = 2'd1;
   localparam logic [1:0] ERR_RANGE = 2'd2;
   localparam logic [1:0] ERR_FULL  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_NEWV,
      ST_EDGE,
      ST_TRI,
      ST_REJ
   } mvdi_state_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } mvdi_lookup_type;

endpackage

/* hw/rtl/mvdi_bucket_store.sv */
// Bucket memories: fill counts and way entries per particle, with the clearing sweep.
module mvdi_bucket_store
   import mvdi_pkg::*;
#(
   parameter int MAX_PARTICLES     = 1024,
   parameter int MAX_MESH_VERTICES = 4096,
   parameter int BUCKET_WAYS       = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [(MAX_PARTICLES > 1 ? $clog2(MAX_PARTICLES) : 1)-1:0] rd_pid,
   input  logic [TEX_W-1:0]     lk_tex,
   input  logic                 wr_en,
   input  logic [(MAX_PARTICLES > 1 ? $clog2(MAX_PARTICLES) : 1)-1:0] wr_pid,
   input  logic [(BUCKET_WAYS > 1 ? $clog2(BUCKET_WAYS) : 1)-1:0] wr_slot,
   input  logic [TEX_W-1:0]     wr_tex,
   input  logic [$clog2(MAX_MESH_VERTICES)-1:0] wr_idx,
   output mvdi_lookup_type      status,
   output logic [$clog2(MAX_MESH_VERTICES)-1:0] hit_idx,
   output logic [$clog2(BUCKET_WAYS + 1)-1:0] fill
);

   localparam int PID_W  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int SLOT_W = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
   localparam int FILL_W = $clog2(BUCKET_WAYS + 1);
   localparam int IDX_W  = $clog2(MAX_MESH_VERTICES);
   localparam int EW     = TEX_W + IDX_W;
   localparam int ROW_W  = BUCKET_WAYS * EW;
   localparam logic [PID_W-1:0] CLR_LAST = PID_W'(MAX_PARTICLES - 1);

   logic [ROW_W-1:0]  way_mem [MAX_PARTICLES];
   logic [FILL_W-1:0] fill_mem [MAX_PARTICLES];

   logic [ROW_W-1:0]  row_ff;
   logic [FILL_W-1:0] fill_ff;
   logic              busy_ff, busy_in;
   logic [PID_W-1:0]  clr_ff, clr_in;
   logic              fill_we;
   logic [PID_W-1:0]  fill_addr;
   logic [FILL_W-1:0] fill_wd;
   logic              hit;
   logic [IDX_W-1:0]  hidx;

   // The sweep zeroes one fill count per cycle after reset.
   always_comb begin
      clr_in    = clr_ff + PID_W'(1);
      busy_in   = busy_ff && (clr_ff != CLR_LAST);
      fill_we   = busy_ff || wr_en;
      fill_addr = busy_ff ? clr_ff : wr_pid;
      fill_wd   = busy_ff ? '0 : FILL_W'(wr_slot) + FILL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         if (busy_ff) begin
            clr_ff <= clr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_addr] <= fill_wd;
      end
      for (int w = 0; w < BUCKET_WAYS; w++) begin
         if (wr_en && !busy_ff && wr_slot == SLOT_W'(w)) begin
            way_mem[wr_pid][w*EW +: EW] <= {wr_tex, wr_idx};
         end
      end
      fill_ff <= fill_mem[rd_pid];
      row_ff  <= way_mem[rd_pid];
   end

   // Only ways below the fill count hold written entries; the lowest match wins.
   always_comb begin
      hit  = 1'b0;
      hidx = '0;
      for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
         if (FILL_W'(w) < fill_ff && row_ff[w*EW + IDX_W +: TEX_W] == lk_tex) begin
            hit  = 1'b1;
            hidx = row_ff[w*EW +: IDX_W];
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.hit  = hit;
   assign hit_idx     = hidx;
   assign fill        = fill_ff;

endmodule

/* hw/rtl/mesh_vertex_dedup_indexer.sv */
// Top level of the mesh vertex deduplication indexer: face sequencer and result register.
//
//   Channel  Direction  Handshake                         Carries
//   req_     in         req_valid / req_stall             one face: size, three corners
//   rsp_     out        rsp_valid / rsp_stall             one result: vertex, edge, triangle or reject
//   csr_     in/out     psel, penable, pwrite, pready     particle_count at byte address 0
//
// A face is accepted, then each corner is looked up in the bucket memories, then the new-vertex
// pass visits each corner, then the edge results and, for a triangle, the triangle result follow;
// a face rejected on size or range goes from its acceptance straight to its reject result.
// The bucket memory read is registered, so each corner's bucket is read ahead of its lookup.
// After reset a sweep clears the fill counts of all MAX_PARTICLES particles, and no face is taken then.
// A stalled result register holds its transfer and holds the sequencer where it would emit.
module mesh_vertex_dedup_indexer
   import mvdi_pkg::*;
#(
   parameter int MAX_PARTICLES     = 1024,
   parameter int MAX_MESH_VERTICES = 4096,
   parameter int BUCKET_WAYS       = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SIZE_W-1:0]     req_face_size,
   input  logic [VID_W-1:0]      req_corner0_vertex,
   input  logic [TEX_W-1:0]      req_corner0_texture,
   input  logic [VID_W-1:0]      req_corner1_vertex,
   input  logic [TEX_W-1:0]      req_corner1_texture,
   input  logic [VID_W-1:0]      req_corner2_vertex,
   input  logic [TEX_W-1:0]      req_corner2_texture,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [OIDX_W-1:0]     rsp_first_index,
   output logic [OIDX_W-1:0]     rsp_second_index,
   output logic [OIDX_W-1:0]     rsp_third_index,
   output logic [OPART_W-1:0]    rsp_particle_index,
   output logic [TEX_W-1:0]      rsp_texture_code,
   output logic [1:0]            rsp_error_code,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int PID_W  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int SLOT_W = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
   localparam int FILL_W = $clog2(BUCKET_WAYS + 1);
   localparam int IDX_W  = $clog2(MAX_MESH_VERTICES);
   localparam int TOT_W  = $clog2(MAX_MESH_VERTICES + 1);
   localparam logic [VID_W-1:0] VID_MAX =
      (MAX_PARTICLES >= 2047) ? {VID_W{1'b1}} : VID_W'(MAX_PARTICLES);
   localparam logic [FILL_W:0] WAYS_LIM = (FILL_W + 1)'(BUCKET_WAYS);
   localparam logic [TOT_W:0]  TOT_LIM  = (TOT_W + 1)'(MAX_MESH_VERTICES);

   mvdi_state_type state_ff, state_in;

   logic [1:0]        j_ff, j_in;
   logic [1:0]        e_ff, e_in;
   logic [1:0]        new_cnt_ff, new_cnt_in;
   logic [TOT_W-1:0]  vt_ff, vt_in;
   logic [VID_W-1:0]  pc_ff, pc_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              tri_ff;
   logic [1:0]        err_ff;
   logic [PID_W-1:0]  pid_ff [3];
   logic [TEX_W-1:0]  tex_ff [3];
   logic [IDX_W-1:0]  idx_ff [3];
   logic [SLOT_W-1:0] slot_ff [3];
   logic [2:0]        isnew_ff;

   logic [1:0]        rsp_kind_ff;
   logic [OIDX_W-1:0] rsp_first_ff, rsp_second_ff, rsp_third_ff;
   logic [OPART_W-1:0] rsp_part_ff;
   logic [TEX_W-1:0]  rsp_tex_ff;
   logic [1:0]        rsp_err_ff;
   logic              rsp_last_ff;

   logic [VID_W-1:0]  in_vid [3];
   logic [TEX_W-1:0]  in_tex [3];
   logic [PID_W-1:0]  in_pid [3];
   logic              in_bad;
   logic [1:0]        in_err;
   logic              accept;
   logic              out_free;
   logic              cfg_wr;

   mvdi_lookup_type   st_status;
   logic [IDX_W-1:0]  st_idx;
   logic [FILL_W-1:0] st_fill;
   logic [PID_W-1:0]  rd_pid;

   logic [PID_W-1:0]  cur_pid;
   logic [TEX_W-1:0]  cur_tex;
   logic              m0, m1, eq0, eq1, found, full;
   logic [1:0]        same;
   logic [FILL_W:0]   bsum;
   logic [TOT_W:0]    tsum;
   logic [IDX_W-1:0]  lk_idx, new_idx;
   logic [SLOT_W-1:0] new_slot;
   logic [1:0]        last_j;
   logic              newv_adv;

   logic              emit;
   logic              wr_en;
   logic [1:0]        o_kind;
   logic [OIDX_W-1:0] o_first, o_second, o_third;
   logic [OPART_W-1:0] o_part;
   logic [TEX_W-1:0]  o_tex;
   logic [1:0]        o_err;
   logic              o_last;

   // Configuration register.
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       csr_paddr[CSR_ADDR_W-1] == CSR_PARTICLE_COUNT;
   assign pc_in      = cfg_wr ? csr_pwdata[VID_W-1:0] : pc_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_PARTICLE_COUNT) ?
                       {(CSR_DATA_W - VID_W)'(0), pc_ff} : '0;

   // Face check on the input side.
   assign in_vid[0] = req_corner0_vertex;
   assign in_vid[1] = req_corner1_vertex;
   assign in_vid[2] = req_corner2_vertex;
   assign in_tex[0] = req_corner0_texture;
   assign in_tex[1] = req_corner1_texture;
   assign in_tex[2] = req_corner2_texture;

   always_comb begin
      in_bad = 1'b0;
      for (int j = 0; j < 3; j++) begin
         in_pid[j] = PID_W'(in_vid[j] - VID_W'(1));
         if ((j < 2 || req_face_size == SIZE_TRI) &&
             (in_vid[j] == '0 || in_vid[j] > pc_ff || in_vid[j] > VID_MAX)) begin
            in_bad = 1'b1;
         end
      end
      if (req_face_size != SIZE_EDGE && req_face_size != SIZE_TRI) begin
         in_err = ERR_SIZE;
      end else if (in_bad) begin
         in_err = ERR_RANGE;
      end else begin
         in_err = ERR_NONE;
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || st_status.busy;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   mvdi_bucket_store #(
      .MAX_PARTICLES     (MAX_PARTICLES),
      .MAX_MESH_VERTICES (MAX_MESH_VERTICES),
      .BUCKET_WAYS       (BUCKET_WAYS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_pid  (rd_pid),
      .lk_tex  (cur_tex),
      .wr_en   (wr_en),
      .wr_pid  (cur_pid),
      .wr_slot (slot_ff[j_ff]),
      .wr_tex  (cur_tex),
      .wr_idx  (idx_ff[j_ff]),
      .status  (st_status),
      .hit_idx (st_idx),
      .fill    (st_fill)
   );

   // Corner resolution: the bucket read first, then pairs that earlier corners of this face add.
   always_comb begin
      cur_pid  = pid_ff[j_ff];
      cur_tex  = tex_ff[j_ff];
      m0       = (j_ff != 2'd0) && isnew_ff[0] && pid_ff[0] == cur_pid;
      m1       = (j_ff == 2'd2) && isnew_ff[1] && pid_ff[1] == cur_pid;
      eq0      = m0 && tex_ff[0] == cur_tex;
      eq1      = m1 && tex_ff[1] == cur_tex;
      found    = st_status.hit || eq0 || eq1;
      lk_idx   = st_status.hit ? st_idx : (eq0 ? idx_ff[0] : idx_ff[1]);
      same     = {1'b0, m0} + {1'b0, m1};
      bsum     = {1'b0, st_fill} + (FILL_W + 1)'(same);
      tsum     = {1'b0, vt_ff} + (TOT_W + 1)'(new_cnt_ff);
      full     = !found && (bsum >= WAYS_LIM || tsum >= TOT_LIM);
      new_idx  = IDX_W'(tsum);
      new_slot = SLOT_W'(bsum);
      last_j   = tri_ff ? 2'd2 : 2'd1;
      newv_adv = !isnew_ff[j_ff] || out_free;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (in_err != ERR_NONE) ? ST_REJ : ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (full) begin
               state_in = ST_REJ;
            end else if (j_ff == last_j) begin
               state_in = ST_NEWV;
            end
         end
         ST_NEWV: begin
            if (newv_adv && j_ff == last_j) begin
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            if (out_free) begin
               if (!tri_ff) begin
                  state_in = ST_IDLE;
               end else if (e_ff == 2'd2) begin
                  state_in = ST_TRI;
               end
            end
         end
         ST_TRI: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_REJ: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      emit     = 1'b0;
      wr_en    = 1'b0;
      o_kind   = KIND_NEWV;
      o_first  = '0;
      o_second = '0;
      o_third  = '0;
      o_part   = '0;
      o_tex    = '0;
      o_err    = ERR_NONE;
      o_last   = 1'b0;
      rd_pid   = pid_ff[0];
      case (state_ff)
         ST_IDLE: begin
            rd_pid = in_pid[0];
         end
         ST_LOOK: begin
            // Read the next corner's bucket while this one resolves.
            rd_pid = (j_ff == 2'd0) ? pid_ff[1] : pid_ff[2];
         end
         ST_NEWV: begin
            if (isnew_ff[j_ff] && out_free) begin
               emit    = 1'b1;
               wr_en   = 1'b1;
               o_kind  = KIND_NEWV;
               o_first = OIDX_W'(idx_ff[j_ff]);
               o_part  = OPART_W'(cur_pid);
               o_tex   = cur_tex;
            end
         end
         ST_EDGE: begin
            emit   = out_free;
            o_kind = KIND_EDGE;
            o_last = !tri_ff;
            case (e_ff)
               2'd0: begin
                  o_first  = OIDX_W'(idx_ff[0]);
                  o_second = OIDX_W'(idx_ff[1]);
               end
               2'd1: begin
                  o_first  = OIDX_W'(idx_ff[1]);
                  o_second = OIDX_W'(idx_ff[2]);
               end
               default: begin
                  o_first  = OIDX_W'(idx_ff[2]);
                  o_second = OIDX_W'(idx_ff[0]);
               end
            endcase
         end
         ST_TRI: begin
            emit     = out_free;
            o_kind   = KIND_TRI;
            o_first  = OIDX_W'(idx_ff[0]);
            o_second = OIDX_W'(idx_ff[1]);
            o_third  = OIDX_W'(idx_ff[2]);
            o_last   = 1'b1;
         end
         ST_REJ: begin
            emit   = out_free;
            o_kind = KIND_REJ;
            o_err  = err_ff;
            o_last = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Counters.
   always_comb begin
      j_in         = j_ff;
      e_in         = e_ff;
      new_cnt_in   = new_cnt_ff;
      vt_in        = wr_en ? vt_ff + TOT_W'(1) : vt_ff;
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      case (state_ff)
         ST_IDLE: begin
            j_in       = 2'd0;
            e_in       = 2'd0;
            new_cnt_in = 2'd0;
         end
         ST_LOOK: begin
            j_in = (j_ff == last_j) ? 2'd0 : j_ff + 2'd1;
            if (!found) begin
               new_cnt_in = new_cnt_ff + 2'd1;
            end
         end
         ST_NEWV: begin
            if (newv_adv) begin
               j_in = (j_ff == last_j) ? 2'd0 : j_ff + 2'd1;
            end
         end
         ST_EDGE: begin
            if (out_free) begin
               e_in = e_ff + 2'd1;
            end
         end
         default: begin
            j_in = j_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         j_ff         <= 2'd0;
         e_ff         <= 2'd0;
         new_cnt_ff   <= 2'd0;
         vt_ff        <= '0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         e_ff         <= e_in;
         new_cnt_ff   <= new_cnt_in;
         vt_ff        <= vt_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Face registers and the result register.
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int j = 0; j < 3; j++) begin
            pid_ff[j] <= in_pid[j];
            tex_ff[j] <= in_tex[j];
         end
         tri_ff <= (req_face_size == SIZE_TRI);
         err_ff <= in_err;
      end
      if (state_ff == ST_LOOK) begin
         idx_ff[j_ff]   <= found ? lk_idx : new_idx;
         isnew_ff[j_ff] <= !found;
         slot_ff[j_ff]  <= new_slot;
         if (full) begin
            err_ff <= ERR_FULL;
         end
      end
      if (emit) begin
         rsp_kind_ff   <= o_kind;
         rsp_first_ff  <= o_first;
         rsp_second_ff <= o_second;
         rsp_third_ff  <= o_third;
         rsp_part_ff   <= o_part;
         rsp_tex_ff    <= o_tex;
         rsp_err_ff    <= o_err;
         rsp_last_ff   <= o_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_first_index    = rsp_first_ff;
   assign rsp_second_index   = rsp_second_ff;
   assign rsp_third_index    = rsp_third_ff;
   assign rsp_particle_index = rsp_part_ff;
   assign rsp_texture_code   = rsp_tex_ff;
   assign rsp_error_code     = rsp_err_ff;
   assign rsp_last           = rsp_last_ff;

   // A new-vertex result is always followed by the face's edges.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_NEWV) |-> !rsp_last)
      else $error("new-vertex result marked as last of its face");

   // Only a rejected face carries an error code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_REJ) == (rsp_error_code != ERR_NONE)))
      else $error("error code does not agree with result kind");

   // The table is never written while the fill counts are being cleared.
   assert property (@(posedge clock) disable iff (reset)
      st_status.busy |-> !wr_en)
      else $error("bucket write during the clearing sweep");

endmodule
